// ----- rtl/configurable_crc_engine_unit_assert.svh -----
// Assertion macros used by the CRC engine top level.
`ifndef CONFIGURABLE_CRC_ENGINE_UNIT_ASSERT_SVH
`define CONFIGURABLE_CRC_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRCE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/crce_pkg.sv -----
// Package with the types, constants and helper functions of the CRC engine.
package crce_pkg;

  // Datapath and port widths.
  localparam int unsigned CrcBits   = 32;
  localparam int unsigned WidthBits = 6;
  localparam int unsigned IdxBits   = 3;

  // Configuration register indexes.
  localparam logic [IdxBits-1:0] RegCrcWidth  = 3'd0;
  localparam logic [IdxBits-1:0] RegPoly      = 3'd1;
  localparam logic [IdxBits-1:0] RegInitValue = 3'd2;
  localparam logic [IdxBits-1:0] RegReflected = 3'd3;
  localparam logic [IdxBits-1:0] RegXorOut    = 3'd4;

  // Reset values select CRC-32.
  localparam logic [WidthBits-1:0] RstCrcWidth  = 6'd32;
  localparam logic [CrcBits-1:0]   RstPoly      = 32'h04C1_1DB7;
  localparam logic [CrcBits-1:0]   RstInitValue = 32'hFFFF_FFFF;
  localparam logic                 RstReflected = 1'b1;
  localparam logic [CrcBits-1:0]   RstXorOut    = 32'hFFFF_FFFF;

  // Configuration as seen by the fold logic; width is already clamped.
  typedef struct packed {
    logic [WidthBits-1:0] width;
    logic [CrcBits-1:0]   poly;
    logic [CrcBits-1:0]   init_value;
    logic                 reflected;
    logic [CrcBits-1:0]   xor_out;
  } crc_cfg_t;

  // Full 32-bit bit reversal; callers shift right to reverse over fewer bits.
  function automatic logic [CrcBits-1:0] rev32(input logic [CrcBits-1:0] v);
    logic [CrcBits-1:0] r;
    for (int i = 0; i < CrcBits; i++) begin
      r[i] = v[CrcBits-1-i];
    end
    return r;
  endfunction

endpackage

// ----- rtl/crce_fold.sv -----
// Combinational fold of one byte into the running CRC, both bit orders.
module crce_fold (
  input  crce_pkg::crc_cfg_t cfg_i,
  input  logic [31:0]        crc_i,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  output logic [31:0]        crc_next_o,
  output logic [31:0]        crc_out_o
);
  import crce_pkg::*;

  logic [WidthBits-1:0] align;
  logic [CrcBits-1:0]   mask;
  logic [CrcBits-1:0]   start;
  logic [CrcBits-1:0]   poly_lsb;
  logic [CrcBits-1:0]   poly_msb;
  logic [CrcBits-1:0]   r_lsb;
  logic [CrcBits-1:0]   r_msb;

  // Alignment shift and mask for the active width.
  assign align = 6'd32 - cfg_i.width;
  assign mask  = 32'hFFFF_FFFF >> align;

  // Starting register: init value on restart, else the stored CRC.
  always_comb begin
    if (restart_i) begin
      if (cfg_i.reflected) begin
        start = rev32(cfg_i.init_value & mask) >> align;
      end else begin
        start = cfg_i.init_value & mask;
      end
    end else begin
      start = crc_i & mask;
    end
  end

  // Polynomial in both orientations.
  assign poly_lsb = rev32(cfg_i.poly & mask) >> align;
  assign poly_msb = (cfg_i.poly & mask) << align;

  // Eight LSB-first steps, register right-aligned.
  always_comb begin
    r_lsb = start ^ {24'd0, data_byte_i};
    for (int i = 0; i < 8; i++) begin
      if (r_lsb[0]) begin
        r_lsb = (r_lsb >> 1) ^ poly_lsb;
      end else begin
        r_lsb = r_lsb >> 1;
      end
    end
  end

  // Eight MSB-first steps, register left-aligned in 32 bits so that
  // widths below eight behave as an 8-bit left-aligned register.
  always_comb begin
    r_msb = (start << align) ^ {data_byte_i, 24'd0};
    for (int i = 0; i < 8; i++) begin
      if (r_msb[CrcBits-1]) begin
        r_msb = (r_msb << 1) ^ poly_msb;
      end else begin
        r_msb = r_msb << 1;
      end
    end
  end

  // Select the orientation and apply the final XOR.
  assign crc_next_o = cfg_i.reflected ? (r_lsb & mask) : ((r_msb >> align) & mask);
  assign crc_out_o  = (crc_next_o ^ cfg_i.xor_out) & mask;

endmodule

// ----- rtl/configurable_crc_engine_unit.sv -----
// Top level of the configurable byte-serial CRC engine.
//
// Usage: bytes enter on the in channel (data_byte_i, restart_i) under a
// valid/ready handshake; each accepted transaction yields one transaction on
// the out channel carrying crc_out_o, the running CRC XOR the final value,
// right-aligned in the active width with upper bits zero. Setting restart_i
// loads the initial value before the byte is folded in.
// Configuration goes through the cfg channel (cfg_index_i, cfg_data_i),
// which is always ready; registers are width, polynomial, initial value,
// reflection and final XOR. Write them only while the engine is idle.
// Bytes pass an input register, then the eight-step fold and the result
// register. Throughput is one byte per cycle while out_ready_i stays high, set by
// the single pass of the fold logic between those two registers.
// A stalled receiver holds the result register; the input register still
// takes one more byte, after which in_ready_o drops until out_ready_i rises.
// Reset selects CRC-32 settings and clears the running CRC to zero.
`include "configurable_crc_engine_unit_assert.svh"

module configurable_crc_engine_unit #(
  parameter int unsigned MAX_CRC_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] crc_out_o
);
  import crce_pkg::*;

  localparam int unsigned TopWidth = (MAX_CRC_WIDTH < 32) ? MAX_CRC_WIDTH : 32;
  localparam logic [WidthBits-1:0] TopW = WidthBits'(TopWidth);
  localparam logic [WidthBits-1:0] MinW = 6'd4;

  logic [WidthBits-1:0] crc_width_q;
  logic [CrcBits-1:0]   poly_q;
  logic [CrcBits-1:0]   init_value_q;
  logic                 reflected_q;
  logic [CrcBits-1:0]   xor_out_q;

  logic                 s1_valid_q;
  logic                 s1_valid_d;
  logic [7:0]           s1_data_q;
  logic                 s1_restart_q;
  logic                 out_valid_q;
  logic [CrcBits-1:0]   crc_out_q;
  logic [CrcBits-1:0]   running_crc_q;

  logic                 advance;
  logic [WidthBits-1:0] width_eff;
  logic [CrcBits-1:0]   width_mask;
  crc_cfg_t             fold_cfg;
  logic [CrcBits-1:0]   fold_next;
  logic [CrcBits-1:0]   fold_out;

  // Configuration registers; the channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_width_q  <= RstCrcWidth;
      poly_q       <= RstPoly;
      init_value_q <= RstInitValue;
      reflected_q  <= RstReflected;
      xor_out_q    <= RstXorOut;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegCrcWidth:  crc_width_q  <= cfg_data_i[WidthBits-1:0];
        RegPoly:      poly_q       <= cfg_data_i;
        RegInitValue: init_value_q <= cfg_data_i;
        RegReflected: reflected_q  <= cfg_data_i[0];
        RegXorOut:    xor_out_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the width into the supported range.
  always_comb begin
    priority if (crc_width_q < MinW) begin
      width_eff = MinW;
    end else if (crc_width_q > TopW) begin
      width_eff = TopW;
    end else begin
      width_eff = crc_width_q;
    end
  end

  assign width_mask = 32'hFFFF_FFFF >> (6'd32 - width_eff);

  assign fold_cfg = '{
    width:      width_eff,
    poly:       poly_q,
    init_value: init_value_q,
    reflected:  reflected_q,
    xor_out:    xor_out_q
  };

  // Pipeline flow control.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q    <= data_byte_i;
      s1_restart_q <= restart_i;
    end
  end

  // Byte fold between the input register and the result register.
  crce_fold u_fold (
    .cfg_i       (fold_cfg),
    .crc_i       (running_crc_q),
    .data_byte_i (s1_data_q),
    .restart_i   (s1_restart_q),
    .crc_next_o  (fold_next),
    .crc_out_o   (fold_out)
  );

  // Result register and running CRC.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      running_crc_q <= '0;
    end else if (advance) begin
      out_valid_q   <= 1'b1;
      running_crc_q <= fold_next;
    end else if (out_ready_i) begin
      out_valid_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      crc_out_q <= fold_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_out_o   = crc_out_q;

  // Checks on the pipeline and datapath.
  `CRCE_ASSERT_IMPLIES(a_full_blocks, clk_i, rst_ni, s1_valid_q && out_valid_q && !out_ready_i, !in_ready_o, "input accepted while both stages are full")
  `CRCE_ASSERT_NEXT(a_crc_holds, clk_i, rst_ni, !advance, $stable(running_crc_q), "running CRC changed without a byte moving on")
  `CRCE_ASSERT_NEXT(a_advance_valid, clk_i, rst_ni, advance, out_valid_q, "folded byte produced no result")
  `CRCE_ASSERT_IMPLIES(a_out_in_width, clk_i, rst_ni, out_valid_o, (crc_out_o & ~width_mask) == '0, "result has bits above the CRC width")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the configurable byte-serial CRC engine.
module tb_top;
  import crce_pkg::*;

  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned MaxCrcWidth = 32;
  localparam int unsigned ByteTarget  = 700;
  localparam int unsigned MaxGap      = 12;
  localparam int unsigned NumPresets  = 12;

  // Index past the last register; writes to it must leave every setting alone.
  localparam logic [IdxBits-1:0] RegSpare = 3'd7;

  // Shapes of a random message.
  typedef enum logic [1:0] {
    MsgFresh,
    MsgResume,
    MsgNoisy
  } msg_kind_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [IdxBits-1:0] cfg_index_i = '0;
  logic [CrcBits-1:0] cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i = '0;
  logic               restart_i   = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CrcBits-1:0] crc_out_o;

  // Shadow copy of the engine settings and its running CRC.
  crc_cfg_t           shadow_cfg;
  logic [CrcBits-1:0] crc_state;
  logic [CrcBits-1:0] crc_expect_q[$];
  logic [CrcBits-1:0] crc_want;
  int unsigned        bytes_sent  = 0;
  int unsigned        error_count = 0;
  bit                 no_gaps     = 1'b0;

  configurable_crc_engine_unit #(
    .MAX_CRC_WIDTH(MaxCrcWidth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .crc_out_o  (crc_out_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Idle cycles before the next transaction on either side.
  function automatic int unsigned pick_gap();
    if (no_gaps) begin
      return 0;
    end
    return $urandom_range(0, MaxGap);
  endfunction

  // Width actually in use: the register value clamped to the supported range.
  function automatic int unsigned width_in_use();
    int unsigned limit_w;
    limit_w = (MaxCrcWidth < CrcBits) ? MaxCrcWidth : CrcBits;
    if (shadow_cfg.width < 4) begin
      return 4;
    end
    if (shadow_cfg.width > limit_w) begin
      return limit_w;
    end
    return shadow_cfg.width;
  endfunction

  function automatic logic [CrcBits-1:0] width_mask(int unsigned n);
    logic [63:0] m;
    m = (64'd1 << n) - 64'd1;
    return m[CrcBits-1:0];
  endfunction

  // Mirror the low n bits of v.
  function automatic logic [CrcBits-1:0] reverse_low(logic [CrcBits-1:0] v, int unsigned n);
    logic [CrcBits-1:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      r = (r << 1) | CrcBits'(v[i]);
    end
    return r;
  endfunction

  // Register contents after folding one byte with the current settings.
  function automatic logic [CrcBits-1:0] crc_next(logic [CrcBits-1:0] cur, logic [7:0] b,
                                                  logic rs);
    int unsigned        w;
    int unsigned        a;
    int unsigned        s;
    logic [CrcBits-1:0] m;
    logic [CrcBits-1:0] p;
    logic [63:0]        r;
    logic [63:0]        pa;
    logic [63:0]        am;
    logic               msb;
    w = width_in_use();
    m = width_mask(w);
    if (rs) begin
      r = shadow_cfg.reflected ? 64'(reverse_low(shadow_cfg.init_value & m, w))
                               : 64'(shadow_cfg.init_value & m);
    end else begin
      r = 64'(cur & m);
    end
    // Reflected: shift right with the mirrored polynomial.
    if (shadow_cfg.reflected) begin
      p = reverse_low(shadow_cfg.poly & m, w);
      r = r ^ 64'(b);
      for (int i = 0; i < 8; i++) begin
        r = r[0] ? ((r >> 1) ^ 64'(p)) : (r >> 1);
      end
      return r[CrcBits-1:0] & m;
    end
    // Normal: shift left, narrow widths run left-aligned in eight bits.
    a  = (w < 8) ? 8 : w;
    s  = a - w;
    am = 64'(width_mask(a));
    pa = 64'(shadow_cfg.poly & m) << s;
    r  = (r << s) ^ (64'(b) << (a - 8));
    for (int i = 0; i < 8; i++) begin
      msb = r[a-1];
      r   = (r << 1) & am;
      if (msb) begin
        r = r ^ pa;
      end
    end
    r = r >> s;
    return r[CrcBits-1:0] & m;
  endfunction

  function automatic crc_cfg_t make_cfg(logic [WidthBits-1:0] w, logic [CrcBits-1:0] p,
                                        logic [CrcBits-1:0] iv, logic refl,
                                        logic [CrcBits-1:0] xo);
    crc_cfg_t c;
    c.width      = w;
    c.poly       = p;
    c.init_value = iv;
    c.reflected  = refl;
    c.xor_out    = xo;
    return c;
  endfunction

  // Common catalogue settings.
  function automatic crc_cfg_t preset_cfg(int unsigned idx);
    case (idx)
      0:       return make_cfg(6'd32, 32'h04C1_1DB7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      1:       return make_cfg(6'd32, 32'h04C1_1DB7, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
      2:       return make_cfg(6'd16, 32'h0000_8005, 32'h0000_FFFF, 1'b1, 32'h0000_0000);
      3:       return make_cfg(6'd16, 32'h0000_1021, 32'h0000_FFFF, 1'b0, 32'h0000_0000);
      4:       return make_cfg(6'd16, 32'h0000_3D65, 32'h0000_0000, 1'b1, 32'h0000_FFFF);
      5:       return make_cfg(6'd8,  32'h0000_0031, 32'h0000_0000, 1'b1, 32'h0000_0000);
      6:       return make_cfg(6'd8,  32'h0000_0007, 32'h0000_0000, 1'b0, 32'h0000_0000);
      7:       return make_cfg(6'd5,  32'h0000_0005, 32'h0000_001F, 1'b1, 32'h0000_001F);
      8:       return make_cfg(6'd4,  32'h0000_0003, 32'h0000_0000, 1'b1, 32'h0000_0000);
      9:       return make_cfg(6'd7,  32'h0000_0009, 32'h0000_0000, 1'b0, 32'h0000_0000);
      10:      return make_cfg(6'd5,  32'h0000_0009, 32'h0000_0009, 1'b0, 32'h0000_0000);
      default: return make_cfg(6'd12, 32'h0000_080F, 32'h0000_0000, 1'b0, 32'h0000_0000);
    endcase
  endfunction

  task automatic report_error(string what, logic [CrcBits-1:0] got, logic [CrcBits-1:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // One configuration transaction; the shadow settings follow on acceptance.
  task automatic write_reg(logic [IdxBits-1:0] idx, logic [CrcBits-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegCrcWidth:  shadow_cfg.width      = value[WidthBits-1:0];
      RegPoly:      shadow_cfg.poly       = value;
      RegInitValue: shadow_cfg.init_value = value;
      RegReflected: shadow_cfg.reflected  = value[0];
      RegXorOut:    shadow_cfg.xor_out    = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write all five registers; unused upper bits carry noise.
  task automatic load_config(crc_cfg_t c);
    logic [CrcBits-1:0] noise;
    noise = $urandom();
    write_reg(RegCrcWidth, {noise[CrcBits-1:WidthBits], c.width});
    write_reg(RegPoly, c.poly);
    write_reg(RegInitValue, c.init_value);
    noise = $urandom();
    write_reg(RegReflected, {noise[CrcBits-1:1], c.reflected});
    write_reg(RegXorOut, c.xor_out);
  endtask

  // One byte transaction; the expected CRC is queued when it is accepted.
  task automatic send_byte(logic [7:0] b, logic rs);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    restart_i   <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    crc_state = crc_next(crc_state, b, rs);
    crc_expect_q.push_back((crc_state ^ shadow_cfg.xor_out) & width_mask(width_in_use()));
    bytes_sent++;
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_message(int unsigned len, msg_kind_e kind);
    for (int i = 0; i < len; i++) begin
      logic rs;
      case (kind)
        MsgFresh:  rs = (i == 0);
        MsgResume: rs = 1'b0;
        default:   rs = ($urandom_range(0, 3) == 0);
      endcase
      send_byte(8'($urandom_range(0, 255)), rs);
    end
  endtask

  // Reset settings; folding without a restart starts from zero.
  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
  endtask

  // Widths below and above the supported range, with all-ones upper bits.
  task automatic test_width_extremes();
    wait_idle();
    load_config(make_cfg(6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    write_reg(RegSpare, 32'h0000_0000);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    wait_idle();
    write_reg(RegReflected, 32'h0000_0001);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFE, 1'b0);
    wait_idle();
    load_config(make_cfg(6'd63, 32'h04C1_1DB7, 32'h0000_0000, 1'b0, 32'h0000_0000));
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  // Widths under eight bits in both shift directions.
  task automatic test_narrow_widths();
    wait_idle();
    load_config(preset_cfg(9));
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
    wait_idle();
    load_config(preset_cfg(7));
    send_byte(8'h31, 1'b1);
    send_byte(8'h32, 1'b0);
  endtask

  // Settings change between bytes of one message; stored bits carry over.
  task automatic test_config_mid_message();
    wait_idle();
    load_config(preset_cfg(2));
    send_byte(8'h31, 1'b1);
    send_byte(8'h32, 1'b0);
    wait_idle();
    write_reg(RegReflected, 32'h0000_0000);
    write_reg(RegSpare, 32'hFFFF_FFFF);
    send_byte(8'h33, 1'b0);
    wait_idle();
    write_reg(RegCrcWidth, 32'h0000_0008);
    send_byte(8'h34, 1'b0);
  endtask

  // Phases of random settings, each followed by a full drain of results.
  task automatic test_random_messages();
    crc_cfg_t c;
    while (bytes_sent < ByteTarget) begin
      wait_idle();
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        // Single register change, then resume the message in flight.
        case ($urandom_range(0, 5))
          0:       write_reg(RegCrcWidth, $urandom());
          1:       write_reg(RegPoly, $urandom());
          2:       write_reg(RegInitValue, $urandom());
          3:       write_reg(RegReflected, $urandom());
          4:       write_reg(RegXorOut, $urandom());
          default: write_reg(RegSpare, $urandom());
        endcase
        send_message($urandom_range(1, 8), MsgResume);
      end else if ($urandom_range(0, 9) < 6) begin
        load_config(preset_cfg($urandom_range(0, NumPresets - 1)));
      end else begin
        c.width      = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(4, 32));
        c.poly       = $urandom();
        c.init_value = $urandom();
        c.reflected  = 1'($urandom_range(0, 1));
        c.xor_out    = $urandom();
        load_config(c);
      end
      repeat ($urandom_range(1, 4)) begin
        send_message($urandom_range(1, 16),
                     ($urandom_range(0, 9) == 0) ? MsgNoisy : MsgFresh);
      end
    end
  endtask

  // Receiver side: random stalls before each result transaction.
  initial begin : drive_out_ready
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pick_gap();
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (crc_expect_q.size() == 0) begin
        report_error("crc_out with no byte pending", crc_out_o, '0);
      end else begin
        crc_want = crc_expect_q.pop_front();
        if (crc_out_o !== crc_want) begin
          report_error("crc_out", crc_out_o, crc_want);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    shadow_cfg = make_cfg(RstCrcWidth, RstPoly, RstInitValue, RstReflected, RstXorOut);
    crc_state  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_width_extremes();
    test_narrow_widths();
    test_config_mid_message();
    test_random_messages();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("configurable_crc_engine_unit: match");
    end else begin
      $display("configurable_crc_engine_unit: mismatch");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("configurable_crc_engine_unit: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/crce_pkg.sv
rtl/crce_fold.sv
rtl/configurable_crc_engine_unit.sv
bench/tb_top.sv
